// ===== src/wcm_pkg.sv =====
// Shared types, constants and the checksum fold step for the window checksum matcher.
// No dependencies.
package wcm_pkg;

   localparam int WINDOW_BYTES_DEFAULT = 32;
   localparam int NUM_TARGETS_DEFAULT  = 4;

   localparam int BYTE_WIDTH   = 8;
   localparam int SUM_WIDTH    = 16;
   localparam int TARGET_SLOTS = 4;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   // Configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_SUM_0 = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_SUM_1 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_SUM_2 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_SUM_3 = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_ENABLE = 3'd4;

   localparam logic [SUM_WIDTH-1:0] SUM_TOP_BIT  = 16'h8000;
   localparam logic [SUM_WIDTH-1:0] SUM_TOP_FOLD = 16'd3;
   localparam int                   STEP_SHIFT   = 2;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] data_byte;
      logic                  file_start;
   } req_data_type;

   typedef struct packed {
      logic [SUM_WIDTH-1:0]    window_sum;
      logic [TARGET_SLOTS-1:0] match_mask;
   } rsp_data_type;

   // One fold step: XOR in the fold constant on a set top bit, shift, XOR in the byte.
   function automatic logic [SUM_WIDTH-1:0] fold_step(input logic [SUM_WIDTH-1:0] sum,
                                                      input logic [BYTE_WIDTH-1:0] data);
      logic [SUM_WIDTH-1:0] tmp;
      tmp = ((sum & SUM_TOP_BIT) != '0) ? (sum ^ SUM_TOP_FOLD) : sum;
      tmp = tmp << STEP_SHIFT;
      return tmp ^ {{(SUM_WIDTH-BYTE_WIDTH){1'b0}}, data};
   endfunction

endpackage

// ===== src/wcm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module wcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/window_checksum_matcher.sv =====
// Top level of the window checksum matcher: byte ring in RAM, serial fold, target compare.
// Depends on wcm_pkg and wcm_ram.
//
// A byte is accepted only in IDLE; the block then steps through RUN, TAIL and DONE,
// registers the result and stalls new bytes until it is back in IDLE. The single RAM
// read port feeds the fold one window entry per cycle.
// Reset (synchronous, active high) empties the window, zeroes the write position,
// the targets and the enables; the block accepts a transaction in the first cycle after.
module window_checksum_matcher
   import wcm_pkg::*;
#(
   parameter int WINDOW_BYTES = WINDOW_BYTES_DEFAULT,
   parameter int NUM_TARGETS  = NUM_TARGETS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_data_type               req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_data_type               rsp_data,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int AddrWidth = $clog2(WINDOW_BYTES > 1 ? WINDOW_BYTES : 2);
   localparam int CntWidth  = $clog2(WINDOW_BYTES + 1);
   localparam logic [AddrWidth-1:0] LastAddr = AddrWidth'(WINDOW_BYTES - 1);
   localparam logic [CntWidth-1:0]  LastCnt  = CntWidth'(WINDOW_BYTES - 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,   // waiting for a byte
      ST_RUN  = 4'b0010,   // issuing one window read per cycle
      ST_TAIL = 4'b0100,   // last read data folds in
      ST_DONE = 4'b1000    // compare and hand the result to the output register
   } state_type;

   // Advance a ring position with wrap at the window length.
   function automatic logic [AddrWidth-1:0] next_pos(input logic [AddrWidth-1:0] pos);
      return (pos == LastAddr) ? '0 : pos + 1'b1;
   endfunction

   state_type               state_ff, state_in;
   logic [WINDOW_BYTES-1:0] slot_valid_ff, slot_valid_in;
   logic [AddrWidth-1:0]    wr_pos_ff, wr_pos_in;
   logic [AddrWidth-1:0]    rd_pos_ff, rd_pos_in;
   logic [CntWidth-1:0]     rd_cnt_ff, rd_cnt_in;
   logic                    pend_ff, pend_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [SUM_WIDTH-1:0]    sum_ff, sum_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_data_type            rsp_data_ff, rsp_data_in;
   logic [SUM_WIDTH-1:0]    target_ff [NUM_TARGETS];
   logic [NUM_TARGETS-1:0]  enable_ff;

   logic                    req_accept;
   logic [AddrWidth-1:0]    ins_pos;
   logic                    ram_rd_en;
   logic [BYTE_WIDTH-1:0]   ram_rd_data;
   logic [BYTE_WIDTH-1:0]   fold_byte;
   logic [TARGET_SLOTS-1:0] match_mask;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // A new file restarts the ring at slot zero.
   assign ins_pos   = req_data.file_start ? '0 : wr_pos_ff;
   assign ram_rd_en = (state_ff == ST_RUN);

   wcm_ram #(
      .WIDTH (BYTE_WIDTH),
      .DEPTH (WINDOW_BYTES)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (ins_pos),
      .wr_data (req_data.data_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_pos_ff),
      .rd_data (ram_rd_data)
   );

   // Slots never written since the last file start count as zero bytes.
   assign fold_byte = pend_valid_ff ? ram_rd_data : '0;

   // Compare against each enabled target; slots beyond NUM_TARGETS read zero.
   always_comb begin
      match_mask = '0;
      for (int t = 0; t < NUM_TARGETS; t++) begin
         match_mask[t] = enable_ff[t] && (target_ff[t] == sum_ff);
      end
   end

   always_comb begin
      state_in      = state_ff;
      slot_valid_in = slot_valid_ff;
      wr_pos_in     = wr_pos_ff;
      rd_pos_in     = rd_pos_ff;
      rd_cnt_in     = rd_cnt_ff;
      pend_in       = 1'b0;
      pend_valid_in = pend_valid_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      // Drop the result once the consumer takes it.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Fold read data that arrives from the previous cycle's read.
      if (pend_ff) begin
         sum_in = fold_step(sum_ff, fold_byte);
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_data.file_start) begin
                  slot_valid_in = '0;
               end
               slot_valid_in[ins_pos] = 1'b1;
               wr_pos_in = next_pos(ins_pos);
               // The slot after the new byte holds the oldest byte.
               rd_pos_in = next_pos(ins_pos);
               rd_cnt_in = '0;
               sum_in    = '0;
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            pend_in       = 1'b1;
            pend_valid_in = slot_valid_ff[rd_pos_ff];
            rd_pos_in     = next_pos(rd_pos_ff);
            rd_cnt_in     = rd_cnt_ff + 1'b1;
            if (rd_cnt_ff == LastCnt) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hold until the output register is free or being emptied.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.window_sum = sum_ff;
               rsp_data_in.match_mask = match_mask;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_valid_ff <= '0;
         wr_pos_ff     <= '0;
         rd_pos_ff     <= '0;
         rd_cnt_ff     <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
         wr_pos_ff     <= wr_pos_in;
         rd_pos_ff     <= rd_pos_in;
         rd_cnt_ff     <= rd_cnt_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_valid_ff <= pend_valid_in;
      sum_ff        <= sum_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Configuration writes; indexes outside the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < NUM_TARGETS; t++) begin
            target_ff[t] <= '0;
         end
         enable_ff <= '0;
      end else if (csr_wr_en) begin
         for (int t = 0; t < NUM_TARGETS; t++) begin
            if (csr_index == CSR_INDEX_WIDTH'(t)) begin
               target_ff[t] <= csr_wdata[SUM_WIDTH-1:0];
            end
         end
         if (csr_index == CSR_TARGET_ENABLE) begin
            enable_ff <= csr_wdata[NUM_TARGETS-1:0];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== tb/tb_window_checksum_matcher.sv =====
// Self-checking testbench for window_checksum_matcher: a directed table, then random files
// of bytes, each result checked against a local model of the 32-byte window checksum.
// Depends on wcm_pkg and the window_checksum_matcher RTL.
module tb_window_checksum_matcher
   import wcm_pkg::*;
();

   localparam int RING_DEPTH    = WINDOW_BYTES_DEFAULT;
   localparam int RING_ADDR_W   = $clog2(RING_DEPTH > 1 ? RING_DEPTH : 2);
   localparam int SLOT_ADDR_W   = $clog2(TARGET_SLOTS > 1 ? TARGET_SLOTS : 2);
   localparam int NUM_PHASES    = 8;
   localparam int PHASE_BYTES   = 210;
   localparam int STEADY_PHASE  = 2;
   localparam int IDLE_PERCENT  = 27;
   localparam int HOLD_AT_COUNT = 500;
   localparam int HOLD_CYCLES   = 600;
   localparam int TAIL_CYCLES   = 40;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int REPORT_LIMIT  = 10;

   // Register indexes past the last register; writes there must be dropped.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_5 = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_7 = 3'd7;

   typedef enum logic {ROW_BYTE, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CSR_DATA_WIDTH-1:0]  value;
      logic [BYTE_WIDTH-1:0]      data_byte;
      logic                       file_start;
      logic                       typed;
      logic [SUM_WIDTH-1:0]       sum;
      logic [TARGET_SLOTS-1:0]    mask;
   } plan_row_type;

   // Directed opening. Rows with typed set carry a result that is obvious by hand: a byte
   // right after a file start (or reset) leaves a window of zeros ending in that byte, so
   // the checksum equals the byte. All other rows are checked against the local model.
   localparam int DIRECTED_ROWS = 24;
   localparam plan_row_type DIRECTED_PLAN [DIRECTED_ROWS] = '{
      // straight out of reset, every enable clear
      '{kind: ROW_BYTE, data_byte: 8'h00, file_start: 1'b0, typed: 1'b1,
        sum: 16'h0000, mask: 4'h0, default: '0},
      '{kind: ROW_BYTE, data_byte: 8'hFF, file_start: 1'b1, typed: 1'b1,
        sum: 16'h00FF, mask: 4'h0, default: '0},
      '{kind: ROW_CSR, index: CSR_TARGET_SUM_0, value: 16'h00FF, default: '0},
      '{kind: ROW_CSR, index: CSR_TARGET_SUM_1, value: 16'h0000, default: '0},
      '{kind: ROW_CSR, index: CSR_TARGET_SUM_2, value: 16'hFFFF, default: '0},
      '{kind: ROW_CSR, index: CSR_TARGET_SUM_3, value: 16'h0012, default: '0},
      // upper bits of the enable write are dropped: targets 0 and 1 only
      '{kind: ROW_CSR, index: CSR_TARGET_ENABLE, value: 16'hFFF3, default: '0},
      // out-of-range indexes must not alias onto any register
      '{kind: ROW_CSR, index: CSR_UNUSED_5, value: 16'hFFFF, default: '0},
      '{kind: ROW_CSR, index: CSR_UNUSED_7, value: 16'hFFFF, default: '0},
      '{kind: ROW_BYTE, data_byte: 8'hFF, file_start: 1'b1, typed: 1'b1,
        sum: 16'h00FF, mask: 4'h1, default: '0},
      '{kind: ROW_BYTE, data_byte: 8'h00, file_start: 1'b1, typed: 1'b1,
        sum: 16'h0000, mask: 4'h2, default: '0},
      // target 3 equal but still disabled
      '{kind: ROW_BYTE, data_byte: 8'h12, file_start: 1'b1, typed: 1'b1,
        sum: 16'h0012, mask: 4'h0, default: '0},
      '{kind: ROW_CSR, index: CSR_TARGET_ENABLE, value: 16'h000F, default: '0},
      '{kind: ROW_BYTE, data_byte: 8'h12, file_start: 1'b1, typed: 1'b1,
        sum: 16'h0012, mask: 4'h8, default: '0},
      // keep growing the same file so the top bit and the fold come into play
      '{kind: ROW_BYTE, data_byte: 8'h00, file_start: 1'b0, default: '0},
      '{kind: ROW_BYTE, data_byte: 8'hFF, file_start: 1'b0, default: '0},
      '{kind: ROW_BYTE, data_byte: 8'h80, file_start: 1'b0, default: '0},
      '{kind: ROW_BYTE, data_byte: 8'h01, file_start: 1'b0, default: '0},
      '{kind: ROW_BYTE, data_byte: 8'h55, file_start: 1'b0, default: '0},
      '{kind: ROW_BYTE, data_byte: 8'hAA, file_start: 1'b0, default: '0},
      '{kind: ROW_BYTE, data_byte: 8'hFF, file_start: 1'b1, typed: 1'b1,
        sum: 16'h00FF, mask: 4'h1, default: '0},
      '{kind: ROW_CSR, index: CSR_TARGET_ENABLE, value: 16'h0000, default: '0},
      '{kind: ROW_BYTE, data_byte: 8'h00, file_start: 1'b1, typed: 1'b1,
        sum: 16'h0000, mask: 4'h0, default: '0},
      '{kind: ROW_BYTE, data_byte: 8'h7F, file_start: 1'b0, default: '0}
   };

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_valid  = 1'b0;
   logic                       req_stall;
   req_data_type               req_data   = '0;
   logic                       rsp_valid;
   logic                       rsp_stall  = 1'b1;
   rsp_data_type               rsp_data;
   logic                       csr_wr_en  = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index  = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata  = '0;

   // Local copy of the block's state and registers
   bit [BYTE_WIDTH-1:0]   win_ring [RING_DEPTH];
   bit [RING_ADDR_W-1:0]  win_head;
   bit [SUM_WIDTH-1:0]    tgt_sum  [TARGET_SLOTS];
   bit [TARGET_SLOTS-1:0] tgt_en;

   rsp_data_type pending_sums [$];
   int           error_count;
   int           results_seen;
   int           hold_left;
   bit           hold_done;
   bit           steady_flow;
   int           cycle_count;

   int           row;
   int           phase;
   int           n;
   int           t;
   int           file_left;
   req_data_type next_item;

   window_checksum_matcher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Insert one byte into the local window, refold the whole ring oldest first and
   // compare the checksum with every enabled target.
   function automatic rsp_data_type fold_window_after(input req_data_type item);
      bit [SUM_WIDTH-1:0]    acc;
      bit [TARGET_SLOTS-1:0] hits;
      rsp_data_type          res;
      bit [RING_ADDR_W-1:0]  slot;
      if (item.file_start) begin
         foreach (win_ring[i]) win_ring[i] = '0;
         win_head = '0;
      end
      win_ring[win_head] = item.data_byte;
      win_head = RING_ADDR_W'((int'(win_head) + 1) % RING_DEPTH);
      acc = '0;
      for (int i = 0; i < RING_DEPTH; i++) begin
         slot = RING_ADDR_W'((int'(win_head) + i) % RING_DEPTH);
         if (acc[SUM_WIDTH-1]) acc = acc ^ SUM_TOP_FOLD;
         acc = acc << STEP_SHIFT;
         acc = acc ^ {{(SUM_WIDTH-BYTE_WIDTH){1'b0}}, win_ring[slot]};
      end
      hits = '0;
      for (int i = 0; i < TARGET_SLOTS; i++)
         if (tgt_en[i] && tgt_sum[i] == acc) hits[i] = 1'b1;
      res.window_sum = acc;
      res.match_mask = hits;
      return res;
   endfunction

   // Offer one byte, hold it until accepted, then queue what it should produce.
   task automatic offer_byte(input req_data_type item, input bit typed,
                             input rsp_data_type typed_rsp);
      rsp_data_type predicted;
      if (csr_wr_en) csr_wr_en <= 1'b0;
      while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predicted = fold_window_after(item);
      pending_sums.push_back(typed ? typed_rsp : predicted);
   endtask

   // Drop valid and wait until every queued result has come back.
   task automatic drain_pending();
      req_valid <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
   endtask

   // One register write; offer_byte lowers the write enable before the next byte.
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      if (index < TARGET_SLOTS) tgt_sum[index[SLOT_ADDR_W-1:0]] = value;
      else if (index == CSR_TARGET_ENABLE) tgt_en = value[TARGET_SLOTS-1:0];
   endtask

   // Mix of targets: mostly small values that short files actually reach, some full range.
   function automatic logic [CSR_DATA_WIDTH-1:0] pick_target();
      case ($urandom_range(3))
         0, 1:    return 16'($urandom_range(1023));
         2:       return 16'($urandom_range(255));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] pick_byte();
      case ($urandom_range(9))
         0, 1:    return 8'h00;
         2, 3:    return 8'hFF;
         4, 5:    return 8'($urandom_range(15));
         default: return 8'($urandom);
      endcase
   endfunction

   // Result side: check each transaction, then decide the stall for the next cycle.
   initial begin
      error_count  = 0;
      results_seen = 0;
      hold_left    = 0;
      hold_done    = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pending_sums.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("unexpected result: sum %h mask %b",
                           rsp_data.window_sum, rsp_data.match_mask);
            end else begin
               rsp_data_type exp_rsp;
               exp_rsp = pending_sums.pop_front();
               if (rsp_data.window_sum !== exp_rsp.window_sum ||
                   rsp_data.match_mask !== exp_rsp.match_mask) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $display("mismatch on result %0d: sum exp %h got %h, mask exp %b got %b",
                              results_seen, exp_rsp.window_sum, rsp_data.window_sum,
                              exp_rsp.match_mask, rsp_data.match_mask);
               end
            end
         end
         // hold off once for a long stretch so the block backs up into its input
         if (!hold_done && results_seen == HOLD_AT_COUNT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Stimulus
   initial begin
      foreach (win_ring[i]) win_ring[i] = '0;
      foreach (tgt_sum[i]) tgt_sum[i] = '0;
      win_head    = '0;
      tgt_en      = '0;
      steady_flow = 1'b0;
      file_left   = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; register rows wait for the block to go idle first
      for (row = 0; row < DIRECTED_ROWS; row++) begin
         if (DIRECTED_PLAN[row].kind == ROW_CSR) begin
            drain_pending();
            write_csr(DIRECTED_PLAN[row].index, DIRECTED_PLAN[row].value);
         end else begin
            next_item.data_byte = DIRECTED_PLAN[row].data_byte;
            next_item.file_start = DIRECTED_PLAN[row].file_start;
            offer_byte(next_item, DIRECTED_PLAN[row].typed,
                       '{window_sum: DIRECTED_PLAN[row].sum,
                         match_mask: DIRECTED_PLAN[row].mask});
         end
      end

      // random files; each phase reprograms every register while idle
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         drain_pending();
         for (t = 0; t < TARGET_SLOTS; t++) begin
            if (phase == 0) write_csr(CSR_TARGET_SUM_0 + 3'(t), '0);
            else if (phase == NUM_PHASES - 1) write_csr(CSR_TARGET_SUM_0 + 3'(t), 16'hFFFF);
            else write_csr(CSR_TARGET_SUM_0 + 3'(t), pick_target());
         end
         if (phase == 0) write_csr(CSR_TARGET_ENABLE, '0);
         else if (phase == NUM_PHASES - 1) write_csr(CSR_TARGET_ENABLE, 16'h000F);
         else write_csr(CSR_TARGET_ENABLE, 16'($urandom_range(15)));
         steady_flow = (phase == STEADY_PHASE);

         for (n = 0; n < PHASE_BYTES; n++) begin
            // mostly short files, which keep sums low enough to hit targets;
            // longer ones can wrap the ring several times
            next_item.file_start = (file_left == 0);
            if (file_left == 0)
               file_left = ($urandom_range(9) < 6) ? $urandom_range(8, 1) :
                                                     $urandom_range(100, 9);
            file_left--;
            next_item.data_byte = pick_byte();
            offer_byte(next_item, 1'b0, '0);
         end
      end

      steady_flow = 1'b0;
      drain_pending();
      // let any stray result show up before deciding
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_sums.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
